// File: rtl/custom_alphabet_word_sorter_assert.svh
// ----------------------------------------------------------------------------
// Word sorter assertion macros
// Concurrent check wrappers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CUSTOM_ALPHABET_WORD_SORTER_ASSERT_SVH
`define CUSTOM_ALPHABET_WORD_SORTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CAWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word sorter check failed");
// next-cycle implication
`define CAWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word sorter check failed");
`else
`define CAWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CAWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/cawsrt_pkg.sv
// ----------------------------------------------------------------------------
// Word sorter package
// Shared constants, codes, control types and the collation key function.
// ----------------------------------------------------------------------------
package cawsrt_pkg;

    localparam int MAX_WORDS_DEF = 64;
    localparam int MAX_LEN_DEF   = 32;
    localparam int ALPHABET      = 26;
    localparam int LETTER_W      = 5;
    localparam int ORDER_W       = LETTER_W * ALPHABET;
    localparam int CFG_DATA_W    = 60;
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_Z      = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_SORT   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT,
        ST_INS,
        ST_CHK,
        ST_OTH,
        ST_CMP,
        ST_KEY,
        ST_RD_LEN,
        ST_RD_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SORT_BEGIN,
        OP_INS_BEGIN,
        OP_RD_OTHER,
        OP_RD_LENS,
        OP_RD_BYTES,
        OP_KEY_NEXT,
        OP_SHIFT,
        OP_PLACE,
        OP_SORT_END,
        OP_RD_LEN,
        OP_RD_EMIT
    } t_dp_op;

    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        t_action action;
        logic    rd_avail;
        logic    i_done;
        logic    j_zero;
        logic    k_done;
        logic    len_lt;
        logic    key_ne;
        logic    key_lt;
        logic    out_free;
    } t_sts;

    // Collation key: fold bytes above 'Z' down by 32, first matching position wins.
    function automatic logic [LETTER_W-1:0] key_of(input logic [7:0] b,
                                                   input logic [ORDER_W-1:0] order);
        logic [7:0]          c;
        logic [LETTER_W-1:0] k;
        c = b;
        if (c > CHAR_Z) c = c - CASE_OFFSET;
        k = '0;
        for (int p = ALPHABET - 1; p >= 0; p--) begin
            if (CHAR_A + {3'b000, order[LETTER_W*p +: LETTER_W]} == c) k = LETTER_W'(p);
        end
        return k;
    endfunction

endpackage

// File: rtl/cawsrt_if.sv
// ----------------------------------------------------------------------------
// Word sorter channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface cawsrt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] byte_in;
    modport source (output valid, output action, output byte_in, input ready);
    modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface cawsrt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       end_of_word;
    logic       end_of_list;
    logic       overflow;
    modport source (output valid, output byte_out, output end_of_word,
                    output end_of_list, output overflow, input ready);
    modport sink   (input valid, input byte_out, input end_of_word,
                    input end_of_list, input overflow, output ready);
endinterface

interface cawsrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [59:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cawsrt_ctrl.sv
// ----------------------------------------------------------------------------
// Word sorter controller
// Sequences loading, insertion sort and readback beats.
// ----------------------------------------------------------------------------
module cawsrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cawsrt_pkg::t_sts  i_sts,
    output cawsrt_pkg::t_cmd  o_cmd
);

    cawsrt_pkg::t_state r_state;
    cawsrt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cawsrt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cawsrt_pkg::ST_IDLE: begin
                if (i_sts.in_valid) begin
                    if (i_sts.action == cawsrt_pkg::ACT_SORT) n_state = cawsrt_pkg::ST_SORT;
                    else if (i_sts.action == cawsrt_pkg::ACT_READ && i_sts.rd_avail)
                        n_state = cawsrt_pkg::ST_RD_LEN;
                end
            end
            cawsrt_pkg::ST_SORT: n_state = cawsrt_pkg::ST_INS;
            cawsrt_pkg::ST_INS: begin
                n_state = i_sts.i_done ? cawsrt_pkg::ST_IDLE : cawsrt_pkg::ST_CHK;
            end
            cawsrt_pkg::ST_CHK: begin
                n_state = i_sts.j_zero ? cawsrt_pkg::ST_INS : cawsrt_pkg::ST_OTH;
            end
            cawsrt_pkg::ST_OTH: n_state = cawsrt_pkg::ST_CMP;
            cawsrt_pkg::ST_CMP: begin
                if (i_sts.k_done)
                    n_state = i_sts.len_lt ? cawsrt_pkg::ST_CHK : cawsrt_pkg::ST_INS;
                else
                    n_state = cawsrt_pkg::ST_KEY;
            end
            cawsrt_pkg::ST_KEY: begin
                if (i_sts.key_ne)
                    n_state = i_sts.key_lt ? cawsrt_pkg::ST_CHK : cawsrt_pkg::ST_INS;
                else
                    n_state = cawsrt_pkg::ST_CMP;
            end
            cawsrt_pkg::ST_RD_LEN: n_state = cawsrt_pkg::ST_RD_OUT;
            cawsrt_pkg::ST_RD_OUT: begin
                if (i_sts.out_free) n_state = cawsrt_pkg::ST_IDLE;
            end
            default: n_state = cawsrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = cawsrt_pkg::OP_NONE;
        unique case (r_state)
            cawsrt_pkg::ST_IDLE:  o_cmd.in_ready = 1'b1;
            cawsrt_pkg::ST_SORT:  o_cmd.op = cawsrt_pkg::OP_SORT_BEGIN;
            cawsrt_pkg::ST_INS: begin
                o_cmd.op = i_sts.i_done ? cawsrt_pkg::OP_SORT_END : cawsrt_pkg::OP_INS_BEGIN;
            end
            cawsrt_pkg::ST_CHK: begin
                o_cmd.op = i_sts.j_zero ? cawsrt_pkg::OP_PLACE : cawsrt_pkg::OP_RD_OTHER;
            end
            cawsrt_pkg::ST_OTH:   o_cmd.op = cawsrt_pkg::OP_RD_LENS;
            cawsrt_pkg::ST_CMP: begin
                if (i_sts.k_done)
                    o_cmd.op = i_sts.len_lt ? cawsrt_pkg::OP_SHIFT : cawsrt_pkg::OP_PLACE;
                else
                    o_cmd.op = cawsrt_pkg::OP_RD_BYTES;
            end
            cawsrt_pkg::ST_KEY: begin
                if (i_sts.key_ne)
                    o_cmd.op = i_sts.key_lt ? cawsrt_pkg::OP_SHIFT : cawsrt_pkg::OP_PLACE;
                else
                    o_cmd.op = cawsrt_pkg::OP_KEY_NEXT;
            end
            cawsrt_pkg::ST_RD_LEN: o_cmd.op = cawsrt_pkg::OP_RD_LEN;
            cawsrt_pkg::ST_RD_OUT: begin
                if (i_sts.out_free) o_cmd.op = cawsrt_pkg::OP_RD_EMIT;
            end
            default: o_cmd.op = cawsrt_pkg::OP_NONE;
        endcase
    end

endmodule

// File: rtl/cawsrt_dp.sv
// ----------------------------------------------------------------------------
// Word sorter datapath
// Word storage, index and length memories, counters and the output register.
// ----------------------------------------------------------------------------
module cawsrt_dp #(
    parameter int MAX_WORDS = cawsrt_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = cawsrt_pkg::MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cawsrt_in_if.sink         i_in,
    cawsrt_out_if.source      o_out,
    cawsrt_cfg_if.sink        i_cfg,
    input  cawsrt_pkg::t_cmd  i_cmd,
    output cawsrt_pkg::t_sts  o_sts
);

    localparam int WW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int BW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int DEPTH = MAX_WORDS * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    mem_bytes [DEPTH];
    logic [LW-1:0] mem_len   [MAX_WORDS];
    logic [WW-1:0] mem_order [MAX_WORDS];

    logic [cawsrt_pkg::ORDER_W-1:0] r_order;
    logic [CW-1:0] r_count, r_scnt, r_rw, r_i;
    logic [LW-1:0] r_fill, r_k;
    logic [BW-1:0] r_rb;
    logic [WW-1:0] r_j, r_cur, r_oth;
    logic          r_ovf;
    logic [WW-1:0] r_sort_q;
    logic [LW-1:0] r_lena_q, r_lenb_q;
    logic [7:0]    r_byta_q, r_bytb_q;
    logic          r_out_valid, r_out_eow, r_out_eol, r_out_ovf;
    logic [7:0]    r_out_byte;

    logic          accept, cfg_we, list_full, fill_full, eow;
    logic [LW-1:0] min_len;
    logic [cawsrt_pkg::LETTER_W-1:0] key_a, key_b;
    logic [AW-1:0] wr_addr, rda_addr, rdb_addr;
    logic [WW-1:0] ord_raddr, lena_raddr;
    logic          ord_re, len_re, byte_re;
    cawsrt_pkg::t_action act;

    assign act       = cawsrt_pkg::t_action'(i_in.action);
    assign accept    = i_in.valid & i_cmd.in_ready;
    assign cfg_we    = i_cfg.valid;
    assign list_full = (r_count >= CW'(MAX_WORDS));
    assign fill_full = (r_fill >= LW'(MAX_LEN));
    assign min_len   = (r_lena_q < r_lenb_q) ? r_lena_q : r_lenb_q;
    assign key_a     = cawsrt_pkg::key_of(r_byta_q, r_order);
    assign key_b     = cawsrt_pkg::key_of(r_bytb_q, r_order);
    assign eow       = ({1'b0, r_rb} + (BW+1)'(1)) >= (BW+1)'(r_lena_q);

    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
        end else if (cfg_we) begin
            case (i_cfg.index)
                cawsrt_pkg::CFG_ORDER_LOW:  r_order[59:0]    <= i_cfg.data;
                cawsrt_pkg::CFG_ORDER_MID:  r_order[119:60]  <= i_cfg.data;
                cawsrt_pkg::CFG_ORDER_HIGH: r_order[129:120] <= i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

    // memory addressing
    assign wr_addr = AW'(r_count[WW-1:0]) * AW'(MAX_LEN) + AW'(r_fill[BW-1:0]);
    assign ord_raddr  = (i_cmd.op == cawsrt_pkg::OP_RD_OTHER) ? (r_j - WW'(1)) : r_rw[WW-1:0];
    assign ord_re     = (accept && act == cawsrt_pkg::ACT_READ)
                        || (i_cmd.op == cawsrt_pkg::OP_RD_OTHER);
    assign lena_raddr = (i_cmd.op == cawsrt_pkg::OP_RD_LEN) ? r_sort_q : r_cur;
    assign len_re     = (i_cmd.op == cawsrt_pkg::OP_RD_LEN) || (i_cmd.op == cawsrt_pkg::OP_RD_LENS);
    assign byte_re    = (i_cmd.op == cawsrt_pkg::OP_RD_LEN) || (i_cmd.op == cawsrt_pkg::OP_RD_BYTES);
    assign rda_addr   = (i_cmd.op == cawsrt_pkg::OP_RD_LEN)
                        ? AW'(r_sort_q) * AW'(MAX_LEN) + AW'(r_rb)
                        : AW'(r_cur) * AW'(MAX_LEN) + AW'(r_k[BW-1:0]);
    assign rdb_addr   = AW'(r_oth) * AW'(MAX_LEN) + AW'(r_k[BW-1:0]);

    always_ff @(posedge i_clk) begin
        if (accept && act == cawsrt_pkg::ACT_APPEND && !fill_full && !list_full)
            mem_bytes[wr_addr] <= i_in.byte_in;
        if (byte_re) begin
            r_byta_q <= mem_bytes[rda_addr];
            r_bytb_q <= mem_bytes[rdb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (act == cawsrt_pkg::ACT_CLOSE || act == cawsrt_pkg::ACT_SORT)
            && r_fill != '0 && !list_full)
            mem_len[r_count[WW-1:0]] <= r_fill;
        if (len_re) begin
            r_lena_q <= mem_len[lena_raddr];
            r_lenb_q <= mem_len[r_sort_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cawsrt_pkg::OP_SHIFT) mem_order[r_j] <= r_oth;
        else if (i_cmd.op == cawsrt_pkg::OP_PLACE) mem_order[r_j] <= r_cur;
        if (ord_re) r_sort_q <= mem_order[ord_raddr];
    end

    // loading and sort counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_scnt  <= '0;
            r_rw    <= '0;
            r_rb    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_cur   <= '0;
            r_oth   <= '0;
            r_k     <= '0;
        end else begin
            if (accept) begin
                case (act) inside
                    cawsrt_pkg::ACT_APPEND: begin
                        if (fill_full) r_ovf <= 1'b1;
                        else r_fill <= r_fill + LW'(1);
                    end
                    cawsrt_pkg::ACT_CLOSE, cawsrt_pkg::ACT_SORT: begin
                        if (r_fill != '0) begin
                            if (list_full) r_ovf <= 1'b1;
                            else r_count <= r_count + CW'(1);
                        end
                        r_fill <= '0;
                    end
                    default: ;
                endcase
            end
            case (i_cmd.op)
                cawsrt_pkg::OP_SORT_BEGIN: r_i <= '0;
                cawsrt_pkg::OP_INS_BEGIN: begin
                    r_cur <= r_i[WW-1:0];
                    r_j   <= r_i[WW-1:0];
                end
                cawsrt_pkg::OP_RD_LENS: begin
                    r_oth <= r_sort_q;
                    r_k   <= '0;
                end
                cawsrt_pkg::OP_KEY_NEXT: r_k <= r_k + LW'(1);
                cawsrt_pkg::OP_SHIFT:    r_j <= r_j - WW'(1);
                cawsrt_pkg::OP_PLACE:    r_i <= r_i + CW'(1);
                cawsrt_pkg::OP_SORT_END: begin
                    r_scnt <= r_count;
                    r_rw   <= '0;
                    r_rb   <= '0;
                end
                cawsrt_pkg::OP_RD_EMIT: begin
                    if (eow) begin
                        r_rw <= r_rw + CW'(1);
                        r_rb <= '0;
                    end else begin
                        r_rb <= r_rb + BW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == cawsrt_pkg::OP_RD_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cawsrt_pkg::OP_RD_EMIT) begin
            r_out_byte <= r_byta_q;
            r_out_eow  <= eow;
            r_out_eol  <= eow && (r_rw + CW'(1) == r_scnt);
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.byte_out    = r_out_byte;
    assign o_out.end_of_word = r_out_eow;
    assign o_out.end_of_list = r_out_eol;
    assign o_out.overflow    = r_out_ovf;

    always_comb begin
        o_sts.in_valid = i_in.valid;
        o_sts.action   = act;
        o_sts.rd_avail = (r_rw < r_scnt);
        o_sts.i_done   = (r_i >= r_count);
        o_sts.j_zero   = (r_j == '0);
        o_sts.k_done   = (r_k >= min_len);
        o_sts.len_lt   = (r_lena_q < r_lenb_q);
        o_sts.key_ne   = (key_a != key_b);
        o_sts.key_lt   = (key_a < key_b);
        o_sts.out_free = !r_out_valid || o_out.ready;
    end

endmodule

// File: rtl/custom_alphabet_word_sorter.sv
// Append and close beats keep the sequencer idle, ready for another beat. A read beat's
// result passes the order lookup, the length and byte fetch and the output register,
// entering it once the previous result has left. Sort: per word an insertion step and a
// check; per comparison an index read, a length read, then byte fetches and key compares
// till bytes or lengths decide, bound by the single byte compare loop on two read ports.
// Reset is synchronous, active low; word, length and order memories are not cleared.
// ----------------------------------------------------------------------------
// Custom alphabet word sorter
// Loads words byte by byte, sorts them stably under a configurable collation
// order and plays them back byte by byte.
// ----------------------------------------------------------------------------
`include "custom_alphabet_word_sorter_assert.svh"

module custom_alphabet_word_sorter #(
    parameter int MAX_WORDS = cawsrt_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = cawsrt_pkg::MAX_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cawsrt_in_if.sink     i_in,
    cawsrt_out_if.source  o_out,
    cawsrt_cfg_if.sink    i_cfg
);

    // command/status link between sequencer and datapath
    cawsrt_pkg::t_cmd cmd;
    cawsrt_pkg::t_sts sts;

    // handshake terms for the checks below
    logic rd_take;
    logic eol_ok;

    // controller: one state machine covers load, insertion sort and readback
    cawsrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: storage, counters, collation keys and the result register
    cawsrt_dp #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    assign rd_take = i_in.valid && i_in.ready && (i_in.action == cawsrt_pkg::ACT_READ)
                     && sts.rd_avail;
    assign eol_ok  = !o_out.end_of_list || o_out.end_of_word;

    // last byte of the list is always last of its word
    `CAWS_ASSERT_IMP(a_eol_eow, i_clk, i_rst_n, o_out.valid, eol_ok)
    // a read beat with data pending holds off the next beat
    `CAWS_ASSERT_NXT(a_read_busy, i_clk, i_rst_n, rd_take, !i_in.ready)
    // end of sort returns to accepting beats
    `CAWS_ASSERT_NXT(a_sort_done, i_clk, i_rst_n, cmd.op == cawsrt_pkg::OP_SORT_END, i_in.ready)

endmodule
